/* src/serial_command_frame_responder_defines.svh */
// assertion macros for the serial command frame responder
`ifndef SERIAL_COMMAND_FRAME_RESPONDER_DEFINES_SVH
`define SERIAL_COMMAND_FRAME_RESPONDER_DEFINES_SVH

`ifndef SYNTH
`define SCFR_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define SCFR_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define SCFR_ASSERT(name, clk, rstn, prop)
`define SCFR_ASSERT_NEVER(name, clk, rstn, cond)
`endif

`endif

/* src/scfr_pkg.sv */
// types, constants and command codes of the serial command frame responder
package scfr_pkg;

  localparam int unsigned PayloadDepthDef = 8;
  localparam int unsigned JobDepthDef     = 2;
  localparam int unsigned BodyMax         = 7;

  localparam logic [7:0] CHR_U     = 8'h55;
  localparam logic [7:0] CHR_N     = 8'h4E;
  localparam logic [7:0] CHR_E     = 8'h45;
  localparam logic [7:0] CHR_R     = 8'h52;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] HDR_XOR   = CHR_U ^ CHR_N ^ CHR_E ^ CHR_R ^ CHR_COLON;

  localparam logic [7:0] CMD_ALIVE   = 8'hF0;
  localparam logic [7:0] ALIVE_TAIL  = 8'h0D;
  localparam logic [7:0] CMD_ECHO    = 8'hFA;
  localparam logic [7:0] CMD_BUTTONS = 8'hFD;
  localparam logic [7:0] CMD_LED_SET = 8'hFC;
  localparam logic [7:0] CMD_LED_RD  = 8'hFB;
  localparam logic [7:0] CMD_UNKNOWN = 8'hDD;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [3:0] button_levels;
  } req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_of_frame;
    logic [3:0] led_drive;
  } rsp_t;

  // one response to send: body bytes and the led levels after the command
  typedef struct packed {
    logic [2:0]                 body_len;
    logic [BodyMax-1:0][7:0]    body;
    logic [3:0]                 led;
  } job_t;

endpackage

/* src/scfr_front.sv */
// frame parser: checks header and checksum, runs the command, queues the response
module scfr_front #(
  parameter int unsigned PAYLOAD_DEPTH = scfr_pkg::PayloadDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  scfr_pkg::req_t     req_i,
  output logic               job_push_o,
  output scfr_pkg::job_t     job_o
);

  localparam int unsigned PosW = $clog2(PAYLOAD_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(PAYLOAD_DEPTH);

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_GOT_U = 7'b0000010,
    PH_GOT_N = 7'b0000100,
    PH_GOT_E = 7'b0001000,
    PH_LEN   = 7'b0010000,
    PH_COLON = 7'b0100000,
    PH_BODY  = 7'b1000000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [7:0]      chk_q, chk_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [3:0]      led_q, led_d;
  logic [7:0]      store_q [PAYLOAD_DEPTH];
  logic [7:0]      store_d [PAYLOAD_DEPTH];
  logic            u_check;
  logic            respond;
  logic [7:0]      b;

  assign b = req_i.rx_byte;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    chk_d   = chk_q;
    pos_d   = pos_q;
    led_d   = led_q;
    store_d = store_q;
    u_check = 1'b0;
    respond = 1'b0;
    job_o   = '0;
    job_o.body_len = 3'd1;
    job_o.body[0]  = scfr_pkg::CMD_UNKNOWN;

    case (phase_q)
      PH_GOT_U: begin
        if (b == scfr_pkg::CHR_N) phase_d = PH_GOT_N;
        else u_check = 1'b1;
      end
      PH_GOT_N: begin
        if (b == scfr_pkg::CHR_E) phase_d = PH_GOT_E;
        else u_check = 1'b1;
      end
      PH_GOT_E: begin
        if (b == scfr_pkg::CHR_R) phase_d = PH_LEN;
        else u_check = 1'b1;
      end
      PH_LEN: begin
        cnt_d   = b;
        phase_d = PH_COLON;
      end
      PH_COLON: begin
        if (b == scfr_pkg::CHR_COLON) begin
          chk_d      = scfr_pkg::HDR_XOR ^ cnt_q;
          store_d[0] = cnt_q;
          pos_d      = PosW'(1);
          phase_d    = PH_BODY;
        end else begin
          u_check = 1'b1;
        end
      end
      PH_BODY: begin
        if (cnt_q inside {[8'd2:8'd127]}) begin
          if (pos_q < PosW'(PAYLOAD_DEPTH)) begin
            store_d[pos_q[IdxW-1:0]] = b;
            pos_d = pos_q + PosW'(1);
          end
          chk_d = chk_q ^ b;
          cnt_d = cnt_q - 8'd1;
        end else begin
          cnt_d   = cnt_q - 8'd1;
          u_check = 1'b1;
          respond = (chk_q == b);
          case (store_q[1])
            scfr_pkg::CMD_ALIVE: begin
              job_o.body_len = 3'd2;
              job_o.body[0]  = scfr_pkg::CMD_ALIVE;
              job_o.body[1]  = scfr_pkg::ALIVE_TAIL;
            end
            scfr_pkg::CMD_ECHO: begin
              job_o.body_len = 3'd7;
              job_o.body[0]  = scfr_pkg::CMD_ECHO;
              for (int k = 1; k < 7; k++) job_o.body[k] = store_q[k+1];
            end
            scfr_pkg::CMD_BUTTONS: begin
              if (respond) begin
                store_d[2] = {4'b0, req_i.button_levels};
                store_d[3] = 8'd0;
              end
              job_o.body_len = 3'd3;
              job_o.body[0]  = scfr_pkg::CMD_BUTTONS;
              job_o.body[1]  = {4'b0, req_i.button_levels};
            end
            scfr_pkg::CMD_LED_SET: begin
              if (respond) begin
                if (store_q[3] == 8'd1) led_d = led_q | store_q[2][3:0];
                else led_d = led_q & ~store_q[2][3:0];
              end
              job_o.body[0] = scfr_pkg::CMD_LED_SET;
            end
            scfr_pkg::CMD_LED_RD: begin
              if (respond) begin
                store_d[2] = {4'b0, led_q};
                store_d[3] = 8'd0;
              end
              job_o.body_len = 3'd3;
              job_o.body[0]  = scfr_pkg::CMD_LED_RD;
              job_o.body[1]  = {4'b0, led_q};
            end
            default: begin
              job_o.body[0] = scfr_pkg::CMD_UNKNOWN;
            end
          endcase
        end
      end
      default: u_check = 1'b1;
    endcase

    // recheck the same byte as a possible frame start
    if (u_check) begin
      if (b == scfr_pkg::CHR_U) begin
        phase_d = PH_GOT_U;
        chk_d   = 8'd0;
      end else begin
        phase_d = PH_IDLE;
      end
    end

    job_o.led = led_d;
  end

  assign job_push_o = accept_i & respond;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      chk_q   <= '0;
      pos_q   <= '0;
      led_q   <= '0;
      for (int i = 0; i < int'(PAYLOAD_DEPTH); i++) store_q[i] <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      chk_q   <= chk_d;
      pos_q   <= pos_d;
      led_q   <= led_d;
      store_q <= store_d;
    end
  end

endmodule

/* src/scfr_job_fifo.sv */
// short queue of pending responses between parser and sender
module scfr_job_fifo #(
  parameter int unsigned DEPTH = scfr_pkg::JobDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  scfr_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output scfr_pkg::job_t data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  scfr_pkg::job_t  mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

/* src/scfr_sender.sv */
// response sender: walks one queued response out a byte at a time with checksum
`include "serial_command_frame_responder_defines.svh"

module scfr_sender (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  scfr_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           empty,
  input  logic           pop,
  output scfr_pkg::rsp_t rsp_o
);

  logic [3:0] idx_q;
  logic [7:0] chk_q;
  logic [7:0] data;
  logic [2:0] body_idx;
  logic       last;
  logic       take;

  assign body_idx = 3'(idx_q - 4'd6);
  assign last     = (idx_q == (4'd6 + 4'(job_i.body_len)));

  always_comb begin
    case (idx_q)
      4'd0:    data = scfr_pkg::CHR_U;
      4'd1:    data = scfr_pkg::CHR_N;
      4'd2:    data = scfr_pkg::CHR_E;
      4'd3:    data = scfr_pkg::CHR_R;
      4'd4:    data = 8'(job_i.body_len) + 8'd1;
      4'd5:    data = scfr_pkg::CHR_COLON;
      default: data = (body_idx < 3'(scfr_pkg::BodyMax)) ? job_i.body[body_idx] : 8'd0;
    endcase
  end

  assign empty               = ~job_valid_i;
  assign rsp_o.tx_byte       = last ? chk_q : data;
  assign rsp_o.last_of_frame = last;
  assign rsp_o.led_drive     = job_i.led;
  assign take                = pop & job_valid_i;
  assign job_pop_o           = take & last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      chk_q <= '0;
    end else if (take) begin
      if (last) begin
        idx_q <= '0;
        chk_q <= '0;
      end else begin
        idx_q <= idx_q + 4'd1;
        chk_q <= chk_q ^ data;
      end
    end
  end

  `SCFR_ASSERT(a_pop_only_on_last, clk_i, rst_ni, job_pop_o |-> last)
  `SCFR_ASSERT_NEVER(a_idle_at_start, clk_i, rst_ni, !job_valid_i && (idx_q != 4'd0))
  `SCFR_ASSERT(a_chk_clear_at_start, clk_i, rst_ni, (idx_q == 4'd0) |-> (chk_q == 8'd0))
  `SCFR_ASSERT(a_idx_in_frame, clk_i, rst_ni, job_valid_i |-> (idx_q <= 4'd13))

endmodule

/* src/serial_command_frame_responder.sv */
// Serial command frame responder.
// Input queue side: one received serial byte and the button levels per request,
// taken when push is high and full is low. A request frame is the header
// U N E R, a length byte, ':', payload bytes and an XOR checksum byte.
// Output queue side: response frame bytes, oldest first, shown while empty is
// low and taken on pop; the checksum byte carries last_of_frame, and every byte
// carries the led levels after its frame's command.
// A parser takes one byte per cycle while full is low and, on a good checksum,
// runs the command and queues a response of 8 to 14 bytes in a job queue
// (JOB_DEPTH deep). The sender drains the head job one byte per cycle while pop
// is high; a response is registered in the job queue and sent once it is the head.
// Throughput: one request per cycle while the job queue has room; full rises
// only when JOB_DEPTH responses wait, which a stalled receiver or a run of short
// frames with long responses causes.
// Reset clears the parse state, the stored payload, the led levels and both
// queues; requests offered while reset is held are dropped.
module serial_command_frame_responder #(
  parameter int unsigned PAYLOAD_DEPTH = scfr_pkg::PayloadDepthDef,
  parameter int unsigned JOB_DEPTH     = scfr_pkg::JobDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  scfr_pkg::req_t req_i,
  output logic           empty,
  input  logic           pop,
  output scfr_pkg::rsp_t rsp_o
);

  logic           job_push, job_pop, job_valid;
  scfr_pkg::job_t job_in, job_head;
  logic           accept;

  assign accept = push & ~full;

  scfr_front #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .req_i     (req_i),
    .job_push_o(job_push),
    .job_o     (job_in)
  );

  scfr_job_fifo #(
    .DEPTH(JOB_DEPTH)
  ) u_job_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (job_pop),
    .valid_o(job_valid),
    .data_o (job_head)
  );

  scfr_sender u_sender (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job_head),
    .job_pop_o  (job_pop),
    .empty      (empty),
    .pop        (pop),
    .rsp_o      (rsp_o)
  );

endmodule
